// ===== design/cvma_pkg.sv =====
// Shared constants and types for the cascaded vector moving average unit.
`timescale 1ns / 1ps
`default_nettype none

package cvma_pkg;

  localparam int MAX_WINDOW = 8;
  localparam int MAX_PASSES = 4;

  localparam int COORD_W    = 24;
  localparam int WIN_W      = 4;
  localparam int PASS_W     = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 4;

  // effective window (1..MAX_WINDOW) and effective pass count (0..MAX_PASSES)
  localparam int FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W  = $clog2(MAX_WINDOW);
  localparam int PCNT_W = $clog2(MAX_PASSES + 1);

  // running window sum and rounded-division operands
  localparam int SUM_W     = COORD_W + $clog2(MAX_WINDOW);
  localparam int NUM_W     = SUM_W + 1;
  localparam int DIV_SHIFT = NUM_W + $clog2(2 * MAX_WINDOW);
  localparam int RECIP_W   = DIV_SHIFT;
  localparam int PROD_W    = NUM_W + RECIP_W;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LEN = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_PASSES     = CFG_INDEX_W'(1);

  typedef logic [2:0][COORD_W-1:0] vec_t;

  // what one cell hands to its neighbor and to the sequencer
  typedef struct packed {
    logic valid;
    logic produced;
    vec_t vec;
  } cvma_res_t;

  // one result item
  typedef struct packed {
    vec_t vec;
    logic last_flag;
    logic empty;
  } cvma_out_t;

endpackage

`default_nettype wire

// ===== design/cvma_cell.sv =====
// One moving-average stage: window history, running sums and rounded divide.
`timescale 1ns / 1ps
`default_nettype none

module cvma_cell import cvma_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic [FILL_W-1:0] win,
  input  logic              in_valid,
  input  vec_t              in_vec,
  output cvma_res_t         res
);

  vec_t                      hist [MAX_WINDOW];
  logic signed [SUM_W-1:0]   sum [3];
  logic [FILL_W-1:0]         fill;

  logic [FILL_W-1:0]         fill_next;
  logic signed [SUM_W-1:0]   sum_next [3];
  logic                      full;
  logic                      produce;
  logic [IDX_W-1:0]          old_idx;
  vec_t                      oldest;

  logic                      s1_valid;
  logic                      s1_prod;
  logic                      s2_valid;
  logic                      s2_prod;
  logic [PROD_W-1:0]         prod [3];
  logic                      neg [3];

  logic [RECIP_W-1:0]        recip_tab [MAX_WINDOW+1];
  logic [RECIP_W-1:0]        recip;

  // reciprocal of twice the window, rounded up, for an exact floor divide
  for (genvar g = 0; g <= MAX_WINDOW; g++) begin : g_recip
    localparam int D = (g == 0) ? 2 : 2 * g;
    localparam longint unsigned M =
      ((64'd1 << DIV_SHIFT) + 64'(D) - 64'd1) / 64'(D);
    assign recip_tab[g] = RECIP_W'(M);
  end

  assign recip   = recip_tab[win];
  assign old_idx = IDX_W'(win - FILL_W'(1));
  assign oldest  = hist[old_idx];
  assign full    = (fill >= win);
  assign fill_next = full ? fill : fill + FILL_W'(1);
  assign produce = (fill_next >= win);

  always_comb begin
    logic signed [SUM_W:0] acc;
    for (int j = 0; j < 3; j++) begin
      acc = $signed({sum[j][SUM_W-1], sum[j]}) + (SUM_W + 1)'($signed(in_vec[j]));
      if (full) begin
        acc = acc - (SUM_W + 1)'($signed(oldest[j]));
      end
      sum_next[j] = SUM_W'(acc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      fill <= '0;
      for (int j = 0; j < 3; j++) sum[j] <= '0;
    end else if (in_valid) begin
      fill <= fill_next;
      for (int j = 0; j < 3; j++) sum[j] <= sum_next[j];
    end
  end

  // shift line: newest sample at the head
  always_ff @(posedge clk) begin
    if (in_valid) begin
      hist[0] <= in_vec;
      for (int i = 1; i < MAX_WINDOW; i++) hist[i] <= hist[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_prod <= produce;
    s2_prod <= s1_prod;
  end

  // magnitude times reciprocal of 2*w: floor((2|s| + w) / 2w)
  always_ff @(posedge clk) begin
    logic [SUM_W-1:0] mag;
    logic [NUM_W-1:0] num;
    for (int j = 0; j < 3; j++) begin
      mag = sum[j][SUM_W-1] ? SUM_W'(-sum[j]) : SUM_W'(sum[j]);
      num = {mag, 1'b0} + NUM_W'(win);
      prod[j] <= PROD_W'(num) * PROD_W'(recip);
      neg[j]  <= sum[j][SUM_W-1];
    end
  end

  always_comb begin
    logic [COORD_W-1:0] q;
    res.valid    = s2_valid;
    res.produced = s2_prod;
    for (int j = 0; j < 3; j++) begin
      q = prod[j][DIV_SHIFT +: COORD_W];
      res.vec[j] = neg[j] ? -q : q;
    end
  end

endmodule

`default_nettype wire

// ===== design/cascaded_vector_moving_average_unit.sv =====
// Top level of the cascaded vector moving average unit: sequencer and cell row.
//
// Usage: vectors enter on the input channel (in_valid / in_stall, fields
// coord_x, coord_y, coord_z, chain_end); smoothed vectors leave on the output
// channel (out_valid / out_stall). A transfer happens on a clock edge with
// valid high and stall low. Register writes use cfg_valid / cfg_ready with
// cfg_index (0 = window_len, 1 = passes) and cfg_data; cfg_ready is always
// high, and every accepted write to a known register clears all stages.
// One vector is in the cell row at a time. With zero passes a vector goes
// straight to the output register (or the holding register if the receiver
// stalls): one vector per cycle while the holding register is empty. With P
// passes a vector walks through P cells, each registering a running-sum
// update, then a reciprocal multiply for the rounded divide, and the next
// vector is taken when the previous one leaves the row (or stops in a cell
// whose window is not yet full). A finished result waits in the output
// register, with one spare holding register behind it, so a stalled receiver
// blocks new input only once both are full. Synchronous reset clears all
// stages, the registers (window_len = 1, passes = 0) and both channels.
`timescale 1ns / 1ps
`default_nettype none

module cascaded_vector_moving_average_unit import cvma_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [COORD_W-1:0]     coord_x,
  input  logic [COORD_W-1:0]     coord_y,
  input  logic [COORD_W-1:0]     coord_z,
  input  logic                   chain_end,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COORD_W-1:0]     smooth_x,
  output logic [COORD_W-1:0]     smooth_y,
  output logic [COORD_W-1:0]     smooth_z,
  output logic                   final_out,
  output logic                   empty_chain,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers, raw as written
  logic [WIN_W-1:0]  window_len;
  logic [PASS_W-1:0] passes;
  logic [FILL_W-1:0] eff_win;
  logic [PCNT_W-1:0] eff_pass;
  logic              cfg_we;

  // sequencer
  logic              busy;
  logic              cur_last;
  logic              start;
  vec_t              start_vec;
  logic              accept;
  vec_t              in_vec;

  // cell row
  logic              cell_in_valid [MAX_PASSES];
  cvma_res_t         res [MAX_PASSES];
  logic [MAX_PASSES-1:0] res_valid_vec;
  logic              clear_cells;

  // completion
  logic              done;
  logic              done_prod;
  vec_t              done_vec;
  logic              comp_valid;
  cvma_out_t         comp;

  // output register and spare holding register
  cvma_out_t         out_reg;
  cvma_out_t         pend;
  logic              pend_valid;
  logic              out_free;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready &&
                     (cfg_index == REG_WINDOW_LEN || cfg_index == REG_PASSES);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WIN_W'(1);
      passes     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_LEN: window_len <= cfg_data[WIN_W-1:0];
        REG_PASSES:     passes     <= cfg_data[PASS_W-1:0];
        default:        ;
      endcase
    end
  end

  // zero window acts as one; clamp both to the row's size
  always_comb begin
    if (window_len == '0) begin
      eff_win = FILL_W'(1);
    end else if (int'(window_len) > MAX_WINDOW) begin
      eff_win = FILL_W'(MAX_WINDOW);
    end else begin
      eff_win = FILL_W'(window_len);
    end
    if (int'(passes) > MAX_PASSES) begin
      eff_pass = PCNT_W'(MAX_PASSES);
    end else begin
      eff_pass = PCNT_W'(passes);
    end
  end

  assign in_vec   = {coord_z, coord_y, coord_x};
  assign in_stall = busy || pend_valid;
  assign accept   = in_valid && !in_stall;

  // with at least one pass, the vector enters cell 0 in the cycle after its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      start <= accept && (eff_pass != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      start_vec <= in_vec;
      cur_last  <= chain_end;
    end
  end

  // a cell passes its average on only when its window is full and the
  // next cell is one of the configured passes
  for (genvar k = 0; k < MAX_PASSES; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_in_valid[k] = start && (PCNT_W'(k) < eff_pass);
      cvma_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .clear    (clear_cells),
        .win      (eff_win),
        .in_valid (cell_in_valid[k]),
        .in_vec   (start_vec),
        .res      (res[k])
      );
    end else begin : g_body
      assign cell_in_valid[k] = res[k-1].valid && res[k-1].produced &&
                                (PCNT_W'(k) < eff_pass);
      cvma_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .clear    (clear_cells),
        .win      (eff_win),
        .in_valid (cell_in_valid[k]),
        .in_vec   (res[k-1].vec),
        .res      (res[k])
      );
    end
    assign res_valid_vec[k] = res[k].valid;
  end

  // the item is finished where it stops in a cell or leaves the last pass
  always_comb begin
    done      = 1'b0;
    done_prod = 1'b0;
    done_vec  = '0;
    for (int k = 0; k < MAX_PASSES; k++) begin
      if (res[k].valid && (!res[k].produced || PCNT_W'(k + 1) == eff_pass)) begin
        done = 1'b1;
        if (res[k].produced) begin
          done_prod = 1'b1;
          done_vec  = done_vec | res[k].vec;
        end
      end
    end
  end

  // a short chain still gives one empty marker on its last vector
  always_comb begin
    if (accept && (eff_pass == '0)) begin
      comp_valid     = 1'b1;
      comp.vec       = in_vec;
      comp.last_flag = chain_end;
      comp.empty     = 1'b0;
    end else begin
      comp_valid     = done && (done_prod || cur_last);
      comp.vec       = done_prod ? done_vec : '0;
      comp.last_flag = cur_last;
      comp.empty     = !done_prod;
    end
  end

  assign clear_cells = (done && cur_last) || cfg_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept && (eff_pass != '0)) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (pend_valid && out_free) begin
      out_valid  <= 1'b1;
      pend_valid <= 1'b0;
    end else if (comp_valid) begin
      if (out_free) begin
        out_valid <= 1'b1;
      end else begin
        pend_valid <= 1'b1;
      end
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  // hold the payload while the receiver stalls
  always_ff @(posedge clk) begin
    if (pend_valid && out_free) begin
      out_reg <= pend;
    end else if (comp_valid) begin
      if (out_free) begin
        out_reg <= comp;
      end else begin
        pend <= comp;
      end
    end
  end

  assign smooth_x    = out_reg.vec[0];
  assign smooth_y    = out_reg.vec[1];
  assign smooth_z    = out_reg.vec[2];
  assign final_out   = out_reg.last_flag;
  assign empty_chain = out_reg.empty;

  // only one cell reports per cycle, since one vector walks the row
  a_one_cell_reports: assert property (@(posedge clk) disable iff (rst)
    $onehot0(res_valid_vec))
    else $error("more than one cell reports at once");

  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid)
    else $error("holding register full while output register empty");

  a_pend_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(pend_valid) |-> $past(out_valid && out_stall))
    else $error("holding register filled without a stalled output");

  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_chain) |->
      (final_out && smooth_x == '0 && smooth_y == '0 && smooth_z == '0))
    else $error("empty marker without final flag or with nonzero vector");

endmodule

`default_nettype wire

// ===== bench/tb_cascaded_vector_moving_average_unit.sv =====
// Self-checking regression bench for the cascaded vector moving average unit.
`timescale 1ns / 1ps

module tb_cascaded_vector_moving_average_unit;
  import cvma_pkg::*;

  // Cycles of nothing moving after which the run is declared hung. The slowest
  // legal quiet stretch is a drain wait plus a full cell walk plus stall bursts.
  localparam int WATCHDOG_LIMIT = 600;
  // Cycles to let the cell row settle once the last expected result is out:
  // enough for the deepest walk, with margin.
  localparam int SETTLE_CYCLES = 2 * MAX_PASSES + 8;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int CALM_ITEMS    = 1450;

  // Register indexes with no register behind them; writes there are dropped.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = CFG_INDEX_W'(3);

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               fin;
    logic               emp;
  } smooth_t;

  // One row of the directed stimulus: either a register write or a vector,
  // and for a vector optionally a hand-written expected result.
  typedef struct {
    bit                     is_reg;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  data;
    logic [COORD_W-1:0]     x;
    logic [COORD_W-1:0]     y;
    logic [COORD_W-1:0]     z;
    logic                   last;
    bit                     typed;
    smooth_t                want;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [COORD_W-1:0]     coord_x = '0;
  logic [COORD_W-1:0]     coord_y = '0;
  logic [COORD_W-1:0]     coord_z = '0;
  logic                   chain_end = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [COORD_W-1:0]     smooth_x;
  logic [COORD_W-1:0]     smooth_y;
  logic [COORD_W-1:0]     smooth_z;
  logic                   final_out;
  logic                   empty_chain;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  cascaded_vector_moving_average_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .coord_z    (coord_z),
    .chain_end  (chain_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .smooth_x   (smooth_x),
    .smooth_y   (smooth_y),
    .smooth_z   (smooth_z),
    .final_out  (final_out),
    .empty_chain(empty_chain),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Smoothing predictor: its own copy of the registers and of every stage's
  // sample history, running sums and fill level.
  // ---------------------------------------------------------------------------
  logic [WIN_W-1:0]  win_reg;
  logic [PASS_W-1:0] pass_reg;
  longint            hist_q [MAX_PASSES][MAX_WINDOW][3];  // [p][0] is the newest
  longint            run_sum [MAX_PASSES][3];
  int                fill_lvl [MAX_PASSES];

  smooth_t pending_avg [$];   // smoothed vectors still owed by the block

  int mismatches = 0;
  int vec_cnt    = 0;
  int res_cnt    = 0;
  int reg_cnt    = 0;
  int phase_cnt  = 0;
  int empty_cnt  = 0;
  bit jitter_on  = 1'b1;      // random gaps and stalls on both channels

  function automatic void clear_stages();
    for (int p = 0; p < MAX_PASSES; p++) begin
      fill_lvl[p] = 0;
      for (int j = 0; j < 3; j++) begin
        run_sum[p][j] = 0;
        for (int i = 0; i < MAX_WINDOW; i++) hist_q[p][i][j] = 0;
      end
    end
  endfunction

  function automatic int eff_window();
    if (win_reg == 0) return 1;
    if (win_reg > MAX_WINDOW) return MAX_WINDOW;
    return int'(win_reg);
  endfunction

  function automatic int eff_passes();
    return (pass_reg > MAX_PASSES) ? MAX_PASSES : int'(pass_reg);
  endfunction

  // Divide by the window, round to nearest, ties away from zero.
  function automatic longint round_avg(longint s, longint w);
    longint mag;
    longint q;
    mag = (s < 0) ? -s : s;
    q   = (2 * mag + w) / (2 * w);
    return (s < 0) ? -q : q;
  endfunction

  // Push one vector through the cascade; returns 1 when a result is due.
  function automatic bit predict_average(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                         logic [COORD_W-1:0] z, logic last,
                                         output smooth_t res);
    longint v [3];
    int     w;
    int     np;
    bit     produced;
    w        = eff_window();
    np       = eff_passes();
    produced = 1'b1;
    res      = '0;
    v[0]     = longint'($signed(x));
    v[1]     = longint'($signed(y));
    v[2]     = longint'($signed(z));
    for (int p = 0; p < np && produced; p++) begin
      // drop the oldest sample once the window is full
      if (fill_lvl[p] >= w)
        for (int j = 0; j < 3; j++) run_sum[p][j] -= hist_q[p][w-1][j];
      for (int i = w - 1; i > 0; i--)
        for (int j = 0; j < 3; j++) hist_q[p][i][j] = hist_q[p][i-1][j];
      for (int j = 0; j < 3; j++) begin
        hist_q[p][0][j] = v[j];
        run_sum[p][j]  += v[j];
      end
      if (fill_lvl[p] < w) fill_lvl[p]++;
      if (fill_lvl[p] < w) produced = 1'b0;
      else
        for (int j = 0; j < 3; j++) v[j] = round_avg(run_sum[p][j], longint'(w));
    end
    if (last) clear_stages();
    if (produced) begin
      res.x   = v[0][COORD_W-1:0];
      res.y   = v[1][COORD_W-1:0];
      res.z   = v[2][COORD_W-1:0];
      res.fin = last;
      res.emp = 1'b0;
      return 1'b1;
    end
    if (last) begin
      // chain too short: one empty marker, zero coordinates
      res.fin = 1'b1;
      res.emp = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Every task starts and ends at a falling edge, so inputs only ever
  // change there and in_valid gets at most one assignment per step.
  // ---------------------------------------------------------------------------
  task automatic send_vec(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                          logic [COORD_W-1:0] z, logic last, bit typed, smooth_t want);
    smooth_t guess;
    bit      fires;
    // insert an idle burst ahead of this vector now and then
    if (jitter_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    coord_x   <= x;
    coord_y   <= y;
    coord_z   <= z;
    chain_end <= last;
    // hold the payload until the transfer happens
    do @(posedge clk); while (in_stall);
    fires = predict_average(x, y, z, last, guess);
    if (typed) pending_avg.push_back(want);
    else if (fires) pending_avg.push_back(guess);
    vec_cnt++;
    @(negedge clk);
  endtask

  // Write a register once the block has drained. An item may still be walking
  // the cells without owing a result, so wait out the deepest walk as well.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (pending_avg.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_WINDOW_LEN) begin
      win_reg = data[WIN_W-1:0];
      clear_stages();
    end else if (idx == REG_PASSES) begin
      pass_reg = data[PASS_W-1:0];
      clear_stages();
    end
    reg_cnt++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly full-range values, with extremes and tiny values (rounding ties).
  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return {1'b0, {(COORD_W-1){1'b1}}};
      1:       return {1'b1, {(COORD_W-1){1'b0}}};
      2, 3:    return COORD_W'($urandom_range(0, 16)) - COORD_W'(8);
      default: return COORD_W'($urandom());
    endcase
  endfunction

  function automatic row_t reg_row(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    row_t r;
    r        = '{default: '0};
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  function automatic row_t vec_row(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                   logic [COORD_W-1:0] z, logic last);
    row_t r;
    r      = '{default: '0};
    r.x    = x;
    r.y    = y;
    r.z    = z;
    r.last = last;
    return r;
  endfunction

  function automatic row_t chk_row(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                   logic [COORD_W-1:0] z, logic last, smooth_t want);
    row_t r;
    r       = vec_row(x, y, z, last);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, none once the run is calm.
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(negedge clk) begin
    if (rst || !jitter_on) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk) begin : check_out
    smooth_t want;
    if (!rst && out_valid && !out_stall) begin
      res_cnt++;
      if (pending_avg.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h final=%b empty=%b", $time,
                 smooth_x, smooth_y, smooth_z, final_out, empty_chain);
        mismatches++;
      end else begin
        want = pending_avg.pop_front();
        if (want.emp) empty_cnt++;
        if (smooth_x !== want.x) begin
          $display("%0t: smooth_x expected %h actual %h", $time, want.x, smooth_x);
          mismatches++;
        end
        if (smooth_y !== want.y) begin
          $display("%0t: smooth_y expected %h actual %h", $time, want.y, smooth_y);
          mismatches++;
        end
        if (smooth_z !== want.z) begin
          $display("%0t: smooth_z expected %h actual %h", $time, want.z, smooth_z);
          mismatches++;
        end
        if (final_out !== want.fin) begin
          $display("%0t: final_out expected %b actual %b", $time, want.fin, final_out);
          mismatches++;
        end
        if (empty_chain !== want.emp) begin
          $display("%0t: empty_chain expected %b actual %b", $time, want.emp, empty_chain);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no channel completes a transfer.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               pending_avg.size());
      $display("cascaded_vector_moving_average_unit regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  row_t dir_rows [$];

  initial begin : stimulus
    int      w;
    int      np;
    int      need;
    int      len;
    int      nchains;
    int      stop_at;
    logic    last;
    bit      open_tail;
    logic [CFG_DATA_W-1:0] w_data;
    logic [CFG_DATA_W-1:0] p_data;

    win_reg  = WIN_W'(1);
    pass_reg = '0;
    clear_stages();

    // Directed part. After reset the block passes vectors straight through.
    dir_rows.push_back(chk_row(24'h7FFFFF, 24'h800000, 24'h000000, 1'b0,
                               smooth_t'{24'h7FFFFF, 24'h800000, 24'h000000, 1'b0, 1'b0}));
    dir_rows.push_back(chk_row(24'h800000, 24'h7FFFFF, 24'h000001, 1'b1,
                               smooth_t'{24'h800000, 24'h7FFFFF, 24'h000001, 1'b1, 1'b0}));
    // window 2, one pass: two minimums average to the minimum exactly
    dir_rows.push_back(reg_row(REG_WINDOW_LEN, CFG_DATA_W'(2)));
    dir_rows.push_back(reg_row(REG_PASSES, CFG_DATA_W'(1)));
    dir_rows.push_back(vec_row(24'h800000, 24'h800000, 24'h7FFFFF, 1'b0));
    dir_rows.push_back(chk_row(24'h800000, 24'h800000, 24'h7FFFFF, 1'b1,
                               smooth_t'{24'h800000, 24'h800000, 24'h7FFFFF, 1'b1, 1'b0}));
    // half-way sums of both signs: ties round away from zero
    dir_rows.push_back(vec_row(24'h000001, 24'hFFFFFF, 24'h000003, 1'b0));
    dir_rows.push_back(vec_row(24'h000002, 24'hFFFFFE, 24'h000000, 1'b0));
    dir_rows.push_back(vec_row(24'h000005, 24'h000005, 24'hFFFFFB, 1'b1));
    // a single-vector chain is too short for a window of two
    dir_rows.push_back(chk_row(24'h123456, 24'h654321, 24'hABCDEF, 1'b1,
                               smooth_t'{24'h000000, 24'h000000, 24'h000000, 1'b1, 1'b1}));
    // oversized window and pass count saturate to the maxima
    dir_rows.push_back(reg_row(REG_WINDOW_LEN, CFG_DATA_W'(15)));
    dir_rows.push_back(reg_row(REG_PASSES, CFG_DATA_W'(15)));
    dir_rows.push_back(vec_row(24'h000100, 24'h000200, 24'h000300, 1'b0));
    dir_rows.push_back(chk_row(24'h7FFFFF, 24'h800000, 24'h000001, 1'b1,
                               smooth_t'{24'h000000, 24'h000000, 24'h000000, 1'b1, 1'b1}));
    // window 3, two passes; writes to unmapped indexes keep the partial chain
    dir_rows.push_back(reg_row(REG_WINDOW_LEN, CFG_DATA_W'(3)));
    dir_rows.push_back(reg_row(REG_PASSES, CFG_DATA_W'(2)));
    dir_rows.push_back(vec_row(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 1'b0));
    dir_rows.push_back(vec_row(24'h7FFFFE, 24'h000001, 24'h800001, 1'b0));
    dir_rows.push_back(reg_row(REG_SPARE_A, CFG_DATA_W'(5)));
    dir_rows.push_back(reg_row(REG_SPARE_B, CFG_DATA_W'(9)));
    dir_rows.push_back(vec_row(24'h000010, 24'hFFFFF0, 24'h000007, 1'b0));
    dir_rows.push_back(vec_row(24'h7FFFFF, 24'h800000, 24'h000000, 1'b0));
    dir_rows.push_back(vec_row(24'h000000, 24'h000000, 24'h7FFFFF, 1'b1));
    // partial chain, then a window write of zero (acts as one) drops it
    dir_rows.push_back(vec_row(24'h00ABCD, 24'hFF1234, 24'h000042, 1'b0));
    dir_rows.push_back(vec_row(24'h111111, 24'h222222, 24'h333333, 1'b0));
    dir_rows.push_back(reg_row(REG_WINDOW_LEN, CFG_DATA_W'(0)));
    dir_rows.push_back(vec_row(24'h444444, 24'hCCCCCC, 24'h800000, 1'b1));
    // pass data of eight masks to zero passes
    dir_rows.push_back(reg_row(REG_PASSES, CFG_DATA_W'(8)));
    dir_rows.push_back(vec_row(24'h5A5A5A, 24'hA5A5A5, 24'hFFFFFF, 1'b1));

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_reg)
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      else
        send_vec(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].last,
                 dir_rows[i].typed, dir_rows[i].want);
    end

    // Random part: phases of one register setting each, filled with chains.
    stop_at = vec_cnt + RANDOM_ITEMS;
    while (vec_cnt < stop_at) begin
      // drop idling for the tail of the run
      if (vec_cnt >= stop_at - (RANDOM_ITEMS - CALM_ITEMS)) jitter_on = 1'b0;
      if (phase_cnt % 5 == 0) begin
        // sweep the corners of the register space
        case ((phase_cnt / 5) % 4)
          0:       begin w_data = CFG_DATA_W'(MAX_WINDOW); p_data = CFG_DATA_W'(MAX_PASSES); end
          1:       begin w_data = CFG_DATA_W'(1);          p_data = CFG_DATA_W'(0);          end
          2:       begin w_data = CFG_DATA_W'(0);          p_data = CFG_DATA_W'(MAX_PASSES); end
          default: begin w_data = CFG_DATA_W'(15);         p_data = CFG_DATA_W'(1);          end
        endcase
      end else begin
        w_data = CFG_DATA_W'($urandom_range(0, 15));
        p_data = CFG_DATA_W'($urandom_range(0, 15));
      end
      if ($urandom_range(0, 5) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                  CFG_DATA_W'($urandom()));
      if ($urandom_range(0, 1)) begin
        write_reg(REG_WINDOW_LEN, w_data);
        write_reg(REG_PASSES, p_data);
      end else begin
        write_reg(REG_PASSES, p_data);
        write_reg(REG_WINDOW_LEN, w_data);
      end
      phase_cnt++;
      w  = eff_window();
      np = eff_passes();
      // shortest chain that yields a result
      need    = np * (w - 1) + 1;
      nchains = $urandom_range(2, 6);
      for (int c = 0; c < nchains; c++) begin
        if ($urandom_range(0, 4) == 0) len = $urandom_range(1, need);
        else len = need + $urandom_range(0, 20);
        // leave the last chain open now and then; the next write drops it
        open_tail = (c == nchains - 1) && ($urandom_range(0, 3) == 0);
        for (int k = 0; k < len; k++) begin
          last = (k == len - 1) && !open_tail;
          // broken chains: an early end marker
          if ($urandom_range(0, 39) == 0) last = 1'b1;
          send_vec(pick_coord(), pick_coord(), pick_coord(), last, 1'b0, '0);
        end
      end
    end

    // Drain: wait for every owed result, then let the cells settle.
    in_valid <= 1'b0;
    while (pending_avg.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d vectors over %0d register settings (%0d register writes)",
             vec_cnt, phase_cnt, reg_cnt);
    $display("checked %0d smoothed results, %0d of them empty-chain markers",
             res_cnt, empty_cnt);
    if (mismatches == 0 && pending_avg.size() == 0) begin
      $display("cascaded_vector_moving_average_unit regression: pass");
    end else begin
      $display("cascaded_vector_moving_average_unit regression: fail");
    end
    $finish;
  end

endmodule
